FILE: rtl/profile_motif_run_extractor_core_macros.svh
// Assertion macros shared by the RTL of the motif run extractor.
// With ASSERT_OFF defined, every macro expands to nothing.
`ifndef PROFILE_MOTIF_RUN_EXTRACTOR_CORE_MACROS_SVH
`define PROFILE_MOTIF_RUN_EXTRACTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every clock edge outside reset.
`define PRMX_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("prmx assertion failed");

// Property checked on every clock edge, reset included.
`define PRMX_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prmx assertion failed");

`else

`define PRMX_ASSERT(lbl, clk, rstn, prop)
`define PRMX_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/prmx_pkg.sv
`timescale 1ns / 1ps

package prmx_pkg;

  // Profile geometry.
  localparam int unsigned MAX_PROFILE_LEN = 65536;
  localparam int unsigned POS_W = $clog2(MAX_PROFILE_LEN);
  localparam int unsigned PEAK_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PROFILE_LEN - 1);

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned PROD_W = SAMPLE_W + CFG_W + 1;
  localparam int unsigned WSCORE_W = PROD_W - 8;
  localparam int unsigned SCORE_W = 48;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned NUM_W = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] SCORE_WEIGHT_RST = 16'd256;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 16'd4;
  localparam logic [CFG_W-1:0] MIN_SCORE_RST = 16'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SCORE_WEIGHT = 2'd0,
    REG_MIN_LENGTH   = 2'd1,
    REG_MIN_SCORE    = 2'd2
  } prmx_reg_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [CFG_W-1:0] score_weight;
    logic [CFG_W-1:0] min_length;
    logic [CFG_W-1:0] min_score;
  } prmx_cfg_t;

  // One item after the weighting stage.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic signed [WSCORE_W-1:0] wscore;
  } prmx_item_t;

endpackage

FILE: rtl/prmx_cfg.sv
`timescale 1ns / 1ps

module prmx_cfg import prmx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output prmx_cfg_t        cfg_o
);

  prmx_cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCORE_WEIGHT: cfg_d.score_weight = cfg_wdata_i;
        REG_MIN_LENGTH:   cfg_d.min_length = cfg_wdata_i;
        REG_MIN_SCORE:    cfg_d.min_score = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_weight <= SCORE_WEIGHT_RST;
      cfg_q.min_length <= MIN_LENGTH_RST;
      cfg_q.min_score <= MIN_SCORE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/prmx_front.sv
`timescale 1ns / 1ps

module prmx_front import prmx_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  input  logic [CFG_W-1:0]           score_weight_i,
  input  logic                       take_ready_i,
  output logic                       item_valid_o,
  output prmx_item_t                 item_o
);

  logic                     valid_q, valid_d;
  prmx_item_t               item_q;
  logic signed [PROD_W-1:0] prod;
  logic                     take;
  logic                     load;

  // The stage frees up when the run tracker takes its item.
  assign take = valid_q && take_ready_i;
  assign in_stall_o = valid_q && !take_ready_i;
  assign load = in_valid_i && !in_stall_o;

  // Q8.8 times Q8.8 gives Q16.16; the arithmetic shift floors back to Q8.8.
  assign prod = sample_i * $signed({1'b0, score_weight_i});

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Item payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.sample <= sample_i;
      item_q.last <= last_i;
      item_q.wscore <= prod[PROD_W-1:8];
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

endmodule

FILE: rtl/prmx_run.sv
`timescale 1ns / 1ps

module prmx_run import prmx_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  prmx_item_t                item_i,
  input  logic [CFG_W-1:0]          min_length_i,
  input  logic [CFG_W-1:0]          min_score_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [POS_W-1:0]          motif_start_o,
  output logic [POS_W-1:0]          motif_end_o,
  output logic [PEAK_W-1:0]         peak_position_o,
  output logic signed [SCORE_W-1:0] motif_score_o,
  output logic [NUM_W-1:0]          motif_number_o
);

  // Run state.
  logic [POS_W-1:0]           position_q, position_d;
  logic                       in_run_q, in_run_d;
  logic [POS_W-1:0]           run_start_q;
  logic [LEN_W-1:0]           run_length_q;
  logic signed [SCORE_W-1:0]  score_sum_q;
  logic signed [SAMPLE_W-1:0] peak_value_q;
  logic [PEAK_W-1:0]          peak_index_q;
  logic [NUM_W-1:0]           next_number_q, next_number_d;
  logic                       out_valid_q, out_valid_d;

  logic                       go;
  logic                       nonzero;
  logic                       fresh;
  logic [POS_W-1:0]           base_start;
  logic [LEN_W-1:0]           base_len;
  logic signed [SCORE_W-1:0]  base_sum;
  logic signed [SAMPLE_W-1:0] base_pv;
  logic [PEAK_W-1:0]          base_pi;
  logic signed [SCORE_W:0]    sum_wide;
  logic signed [SCORE_W-1:0]  upd_sum;
  logic                       peak_hit;
  logic signed [SAMPLE_W-1:0] upd_pv;
  logic [PEAK_W-1:0]          upd_pi;
  logic [LEN_W-1:0]           upd_len;
  logic [POS_W-1:0]           cand_start;
  logic [LEN_W-1:0]           cand_len;
  logic signed [SCORE_W-1:0]  cand_sum;
  logic [PEAK_W-1:0]          cand_pi;
  logic                       close;
  logic                       emit;
  logic [POS_W+1:0]           end_wide;
  logic [POS_W-1:0]           end_pos;

  // The output register can take a new result when empty or being drained.
  assign ready_o = !out_valid_q || !out_stall_i;
  assign go = item_valid_i && ready_o;

  // A nonzero sample on a closed run opens a new one at the current position.
  assign nonzero = item_i.sample != '0;
  assign fresh = !in_run_q;
  assign base_start = fresh ? position_q : run_start_q;
  assign base_len = fresh ? '0 : run_length_q;
  assign base_sum = fresh ? '0 : score_sum_q;
  assign base_pv = fresh ? '0 : peak_value_q;
  assign base_pi = fresh ? {1'b0, position_q} : peak_index_q;

  // Saturating score accumulation.
  assign sum_wide = {base_sum[SCORE_W-1], base_sum}
                  + {{(SCORE_W + 1 - WSCORE_W){item_i.wscore[WSCORE_W-1]}}, item_i.wscore};

  always_comb begin
    if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1]) begin
      upd_sum = sum_wide[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                  : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      upd_sum = sum_wide[SCORE_W-1:0];
    end
  end

  // Peak tracks the first strict maximum above zero, as a 1-based index.
  assign peak_hit = item_i.sample > base_pv;
  assign upd_pv = peak_hit ? item_i.sample : base_pv;
  assign upd_pi = peak_hit ? ({1'b0, position_q} + 1'b1) : base_pi;
  assign upd_len = (base_len == LEN_MAX) ? base_len : base_len + 1'b1;

  // A zero sample closes the open run as it stood; a last nonzero sample
  // closes the run including itself.
  assign cand_start = nonzero ? base_start : run_start_q;
  assign cand_len = nonzero ? upd_len : run_length_q;
  assign cand_sum = nonzero ? upd_sum : score_sum_q;
  assign cand_pi = nonzero ? upd_pi : peak_index_q;
  assign close = nonzero ? item_i.last : in_run_q;
  assign emit = close && (cand_len > {1'b0, min_length_i})
             && (cand_sum > $signed({{(SCORE_W - CFG_W){1'b0}}, min_score_i}));

  // Inclusive end, clamped to the last valid position.
  assign end_wide = {2'b00, cand_start} + {1'b0, cand_len} - 1'b1;
  assign end_pos = (end_wide > {2'b00, POS_LAST}) ? POS_LAST : end_wide[POS_W-1:0];

  // Position, run flag and numbering.
  always_comb begin
    position_d = position_q;
    in_run_d = in_run_q;
    next_number_d = next_number_q;
    if (go) begin
      in_run_d = nonzero && !item_i.last;
      if (item_i.last) begin
        position_d = '0;
        next_number_d = NUM_W'(1);
      end else begin
        if (position_q != POS_LAST) begin
          position_d = position_q + 1'b1;
        end
        if (emit && next_number_q != NUM_MAX) begin
          next_number_d = next_number_q + 1'b1;
        end
      end
    end
  end

  // Output valid: loaded on a taken item, cleared once drained.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ready_o) begin
      out_valid_d = go && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      in_run_q <= 1'b0;
      next_number_q <= NUM_W'(1);
      out_valid_q <= 1'b0;
      run_start_q <= '0;
      run_length_q <= '0;
      score_sum_q <= '0;
      peak_value_q <= '0;
      peak_index_q <= '0;
    end else begin
      position_q <= position_d;
      in_run_q <= in_run_d;
      next_number_q <= next_number_d;
      out_valid_q <= out_valid_d;
      if (go && nonzero) begin
        run_start_q <= base_start;
        run_length_q <= upd_len;
        score_sum_q <= upd_sum;
        peak_value_q <= upd_pv;
        peak_index_q <= upd_pi;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      motif_start_o <= cand_start;
      motif_end_o <= end_pos;
      peak_position_o <= cand_pi;
      motif_score_o <= cand_sum;
      motif_number_o <= next_number_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/profile_motif_run_extractor_core.sv
`timescale 1ns / 1ps
// Motif run extractor for signed Q8.8 profile samples.
// Input channel: in_valid_i / in_stall_o with sample_i and last_i; an item is
// taken on a rising edge with in_valid_i high and in_stall_o low. Output
// channel: out_valid_o / out_stall_i with one motif per item.
// A run of nonzero samples that closes with enough length and score gives one
// motif; samples that close nothing give no output item.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes score_weight,
// min_length and min_score; write it only while the block is idle.
// A motif passes the input register and then the result register before it
// appears on out_valid_o: the weighting multiply sits in front of the input
// register, and the run state update loads the result register.
// Throughput: one item per cycle while out_stall_i stays low, set by the single
// multiply and the single accumulate and compare per item.
// When the receiver stalls, the result register holds its motif, one more
// item waits in the weighting register, and then in_stall_o rises.
// Reset clears the run state, position and numbering and loads the register
// defaults (weight 256, min_length 4, min_score 2).
`include "profile_motif_run_extractor_core_macros.svh"

module profile_motif_run_extractor_core import prmx_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [POS_W-1:0]           motif_start_o,
  output logic [POS_W-1:0]           motif_end_o,
  output logic [PEAK_W-1:0]          peak_position_o,
  output logic signed [SCORE_W-1:0]  motif_score_o,
  output logic [NUM_W-1:0]           motif_number_o
);

  prmx_cfg_t  cfg;
  prmx_item_t item;
  logic       item_valid;
  logic       run_ready;

  // Configuration registers.
  prmx_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register and sample weighting.
  prmx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .score_weight_i (cfg.score_weight),
    .take_ready_i   (run_ready),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  // Run tracking and result register.
  prmx_run u_run (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .min_length_i    (cfg.min_length),
    .min_score_i     (cfg.min_score),
    .ready_o         (run_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motif_start_o   (motif_start_o),
    .motif_end_o     (motif_end_o),
    .peak_position_o (peak_position_o),
    .motif_score_o   (motif_score_o),
    .motif_number_o  (motif_number_o)
  );

  // A waiting item behind a stalled result must back-pressure the input.
  `PRMX_ASSERT(a_stall_chain, clk_i, rst_ni, (item_valid && out_valid_o && out_stall_i |-> in_stall_o))
  // A motif never ends before it starts.
  `PRMX_ASSERT(a_end_order, clk_i, rst_ni, (out_valid_o |-> motif_end_o >= motif_start_o))
  // The peak lies at or after the run start.
  `PRMX_ASSERT(a_peak_order, clk_i, rst_ni, (out_valid_o |-> peak_position_o >= {1'b0, motif_start_o}))
  // Numbering starts from one.
  `PRMX_ASSERT(a_number_nonzero, clk_i, rst_ni, (out_valid_o |-> motif_number_o != '0))
  // No result is shown while reset is held.
  `PRMX_ASSERT_ALWAYS(a_reset_quiet, clk_i, (!rst_ni |-> !out_valid_o))

endmodule

FILE: dv/profile_motif_run_extractor_core_tb.sv
`timescale 1ns / 1ps

module profile_motif_run_extractor_core_tb;
  import prmx_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int LAT_SLACK = 4;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 117;
  localparam longint SCORE_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SCORE_LO = -SCORE_HI - 1;

  // One reported motif.
  typedef struct {
    logic [POS_W-1:0]          first_pos;
    logic [POS_W-1:0]          last_pos;
    logic [PEAK_W-1:0]         peak;
    logic signed [SCORE_W-1:0] score;
    logic [NUM_W-1:0]          number;
  } motif_t;

  // One row of the directed stimulus, with an optional hand-written result.
  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    bit                         lst;
    bit                         typed;
    bit                         has;
    motif_t                     m;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [1:0]                 cfg_idx;
  logic [CFG_W-1:0]           cfg_wdata;
  logic                       in_valid;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last;
  logic                       out_valid_o;
  logic                       out_stall;
  logic [POS_W-1:0]           motif_start_o;
  logic [POS_W-1:0]           motif_end_o;
  logic [PEAK_W-1:0]          peak_position_o;
  logic signed [SCORE_W-1:0]  motif_score_o;
  logic [NUM_W-1:0]           motif_number_o;

  profile_motif_run_extractor_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .sample_i        (in_sample),
    .last_i          (in_last),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .motif_start_o   (motif_start_o),
    .motif_end_o     (motif_end_o),
    .peak_position_o (peak_position_o),
    .motif_score_o   (motif_score_o),
    .motif_number_o  (motif_number_o)
  );

  // Predictor copy of the configuration and the run state.
  logic [CFG_W-1:0] cfg_weight;
  logic [CFG_W-1:0] cfg_min_len;
  logic [CFG_W-1:0] cfg_min_score;
  int unsigned      pos;
  bit               run_open;
  int unsigned      run_first;
  int unsigned      run_len;
  longint           score_acc;
  int               peak_val;
  int unsigned      peak_at;
  int unsigned      next_num;

  motif_t   pending_motifs[$];
  dir_row_t dir_rows[$];
  motif_t   no_motif;
  int       mismatches = 0;
  bit       tx_idle_on = 1'b1;
  bit       rx_idle_on = 1'b1;
  bit       hold_req = 1'b0;
  int       hold_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Closes the open run and builds a motif when it qualifies.
  function automatic bit close_run(output motif_t m);
    int unsigned stop;
    m = '{default: '0};
    run_open = 1'b0;
    if (!(run_len > cfg_min_len && score_acc > longint'(cfg_min_score))) return 1'b0;
    stop = run_first + run_len - 1;
    if (stop > MAX_PROFILE_LEN - 1) stop = MAX_PROFILE_LEN - 1;
    m.first_pos = POS_W'(run_first);
    m.last_pos  = POS_W'(stop);
    m.peak      = PEAK_W'(peak_at);
    m.score     = SCORE_W'(score_acc);
    m.number    = NUM_W'(next_num);
    if (next_num < 32'hFFFF) next_num++;
    return 1'b1;
  endfunction

  // Advances the run state by one accepted sample; returns 1 when a motif results.
  function automatic bit track_sample(input logic signed [SAMPLE_W-1:0] smp, input bit lst,
                                      output motif_t m);
    bit     hit;
    longint acc;
    hit = 1'b0;
    m = '{default: '0};
    if (smp == 0) begin
      if (run_open) hit = close_run(m);
    end else begin
      if (!run_open) begin
        run_open = 1'b1;
        run_first = pos;
        run_len = 0;
        score_acc = 0;
        peak_val = 0;
        peak_at = pos;
      end
      // The arithmetic shift floors the Q16.16 product down to Q8.8.
      acc = score_acc + ((longint'(smp) * longint'(cfg_weight)) >>> 8);
      if (acc > SCORE_HI) acc = SCORE_HI;
      if (acc < SCORE_LO) acc = SCORE_LO;
      score_acc = acc;
      if (int'(smp) > peak_val) begin
        peak_val = int'(smp);
        peak_at = pos + 1;
      end
      if (run_len < LEN_MAX) run_len++;
      if (lst) hit = close_run(m);
    end
    if (lst) begin
      pos = 0;
      next_num = 1;
      run_open = 1'b0;
    end else if (pos < MAX_PROFILE_LEN - 1) begin
      pos++;
    end
    return hit;
  endfunction

  function automatic void check_field(input string what, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  // Mostly short idles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Nonzero sample, biased toward positive values so that runs qualify.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    int r;
    do begin
      r = $urandom_range(0, 99);
      if (r < 55) v = SAMPLE_W'($urandom_range(1, 32767));
      else if (r < 80) v = SAMPLE_W'($urandom());
      else if (r < 90) v = SAMPLE_W'($urandom_range(0, 600)) - 16'sd300;
      else begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0001;
          default: v = 16'shFFFF;
        endcase
      end
    end while (v == 0);
    return v;
  endfunction

  function automatic void tbl_add(input logic signed [SAMPLE_W-1:0] smp, input bit lst,
                                  input bit typed = 1'b0, input bit has = 1'b0,
                                  input int unsigned first = 0, input int unsigned stop = 0,
                                  input int unsigned peak = 0, input longint score = 0,
                                  input int unsigned num = 0);
    dir_row_t row;
    row.smp = smp;
    row.lst = lst;
    row.typed = typed;
    row.has = has;
    row.m.first_pos = POS_W'(first);
    row.m.last_pos = POS_W'(stop);
    row.m.peak = PEAK_W'(peak);
    row.m.score = SCORE_W'(score);
    row.m.number = NUM_W'(num);
    dir_rows.push_back(row);
  endfunction

  // Offers one item, waits until it is taken, and records its expected motif.
  task automatic drive_item(input logic signed [SAMPLE_W-1:0] smp, input bit lst,
                            input bit use_typed, input bit typed_has, input motif_t typed_m);
    motif_t pred;
    bit     hit;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= smp;
    in_last <= lst;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    hit = track_sample(smp, lst, pred);
    if (use_typed) begin
      if (typed_has) pending_motifs.push_back(typed_m);
    end else if (hit) begin
      pending_motifs.push_back(pred);
    end
  endtask

  task automatic feed(input logic signed [SAMPLE_W-1:0] smp, input bit lst);
    drive_item(smp, lst, 1'b0, 1'b0, no_motif);
  endtask

  task automatic tx_gap();
    int n;
    n = (tx_idle_on && hold_left == 0 && !hold_req) ? pick_gap() : 0;
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stops offering items and waits until every expected motif has come out.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_motifs.size() != 0) @(posedge clk);
    repeat (LAT_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input prmx_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCORE_WEIGHT: cfg_weight = val;
      REG_MIN_LENGTH:   cfg_min_len = val;
      REG_MIN_SCORE:    cfg_min_score = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] ml,
                            input logic [CFG_W-1:0] ms);
    write_reg(REG_SCORE_WEIGHT, w);
    write_reg(REG_MIN_LENGTH, ml);
    write_reg(REG_MIN_SCORE, ms);
  endtask

  // One run of random nonzero samples and its closing item, or a lone zero.
  task automatic random_run(inout int count);
    int len;
    int r;
    bit last_in_run;
    bit zero_last;
    r = $urandom_range(0, 99);
    if (r < 8) len = 0;
    else if (r < 92) len = $urandom_range(1, 9);
    else len = $urandom_range(10, 30);
    r = $urandom_range(0, 99);
    last_in_run = (len > 0) && (r >= 78) && (r < 88);
    zero_last = (r >= 88);
    for (int k = 0; k < len; k++) begin
      feed(rand_sample(), last_in_run && (k == len - 1));
      tx_gap();
    end
    count += len;
    if (!last_in_run) begin
      feed(16'sd0, zero_last);
      tx_gap();
      if (len > 0 || zero_last) count++;
    end
  endtask

  // Receiver pacing: random stalls, quiet stretches, and one long hold-off on request.
  initial begin : rx_pace
    int busy_left;
    int free_left;
    bit stall_now;
    busy_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        stall_now = 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        stall_now = 1'b1;
      end else if (!rx_idle_on) begin
        stall_now = 1'b0;
      end else if (busy_left > 0) begin
        stall_now = 1'b1;
        busy_left--;
      end else if (free_left > 0) begin
        stall_now = 1'b0;
        free_left--;
      end else begin
        free_left = $urandom_range(0, 15);
        busy_left = pick_gap();
        stall_now = 1'b0;
      end
      out_stall <= stall_now;
    end
  end

  // Compare each accepted motif with the oldest expectation.
  always @(posedge clk) begin : motif_check
    motif_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_motifs.size() == 0) begin
        mismatches++;
        $display("%0t: motif expected none actual number %0d start %0d", $time,
                 motif_number_o, motif_start_o);
      end else begin
        want = pending_motifs.pop_front();
        check_field("motif_start", want.first_pos, motif_start_o);
        check_field("motif_end", want.last_pos, motif_end_o);
        check_field("peak_position", want.peak, peak_position_o);
        check_field("motif_score", want.score, motif_score_o);
        check_field("motif_number", want.number, motif_number_o);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last = 1'b0;
    cfg_weight = SCORE_WEIGHT_RST;
    cfg_min_len = MIN_LENGTH_RST;
    cfg_min_score = MIN_SCORE_RST;
    pos = 0;
    run_open = 1'b0;
    run_first = 0;
    run_len = 0;
    score_acc = 0;
    peak_val = 0;
    peak_at = 0;
    next_num = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows under the reset configuration (weight 1.0, length > 4, score > 2).
    // An idle zero closes nothing.
    tbl_add(16'sd0, 1'b0, 1'b1, 1'b0);
    // Five samples of 1.0 starting at position 1, closed by a zero.
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sd0, 1'b0, 1'b1, 1'b1, 1, 5, 2, 1280, 1);
    // A run of exactly min_length samples at the positive extreme gives nothing.
    tbl_add(16'sh7FFF, 1'b0);
    tbl_add(16'sh7FFF, 1'b0);
    tbl_add(16'sh7FFF, 1'b0);
    tbl_add(16'sh7FFF, 1'b0);
    tbl_add(16'sd0, 1'b0, 1'b1, 1'b0);
    // A run with no positive sample keeps its peak at the start and scores below zero.
    tbl_add(16'sh8000, 1'b0);
    tbl_add(16'shFFFF, 1'b0);
    tbl_add(16'sd0, 1'b0, 1'b1, 1'b0);
    // Mixed run whose peak moves twice, closed by a nonzero last sample.
    tbl_add(-16'sd256, 1'b0);
    tbl_add(16'sd512, 1'b0);
    tbl_add(16'sd256, 1'b0);
    tbl_add(16'sd768, 1'b0);
    tbl_add(16'sd100, 1'b1);
    // Fresh profile: positions and numbering restart; a zero with last closes the run.
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sh0100, 1'b0);
    tbl_add(16'sd0, 1'b1, 1'b1, 1'b1, 0, 4, 1, 1280, 1);
    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].has,
                 dir_rows[i].m);
      tx_gap();
    end
    quiesce();

    // Random runs over several register settings.
    items = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(16'd256, 16'd1, 16'd0);
        1: set_config(16'd0, 16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'd0, 16'hFFFF);
        3: set_config(16'($urandom()), 16'($urandom_range(0, 8)),
                      16'($urandom_range(0, 3000)));
        4: set_config(16'd1, 16'd2, 16'd0);
        default: set_config(16'($urandom_range(128, 1024)), 16'($urandom_range(0, 5)),
                            16'($urandom_range(0, 500)));
      endcase
      // The first phase starts with a long receiver hold-off so the block backs up.
      if (p == 0) hold_req = 1'b1;
      while (items < (p + 1) * ITEMS_PER_PHASE) random_run(items);
      quiesce();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
